// ===== sv/lrsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrsgd_pkg
// Shared types and constants of the linear regression SGD trainer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrsgd_pkg;

  localparam int LR_W       = 16;
  localparam int RATE_FRAC  = 16;
  localparam logic [LR_W-1:0] LR_RESET = 16'd655;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_LR = 1'b0;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_MULADD = 2'd0;
  localparam alu_op_t ALU_ADD    = 2'd1;
  localparam alu_op_t ALU_SUB    = 2'd2;

  typedef struct packed {
    alu_op_t op;
    logic    rate_shift;
  } alu_ctl_t;

endpackage

`default_nettype wire

// ===== sv/lrsgd_alu.sv =====
// ----------------------------------------------------------------------------
// lrsgd_alu
// Shared unit: saturating multiply-shift with saturating add, add or subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsgd_alu
  import lrsgd_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire alu_ctl_t                      ctl,
  input  wire logic signed [DATA_WIDTH-1:0]  a,
  input  wire logic signed [DATA_WIDTH:0]    b,
  input  wire logic signed [DATA_WIDTH-1:0]  c,
  output logic signed [DATA_WIDTH-1:0]       res
);

  localparam int PW = 2 * DATA_WIDTH + 1;

  localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         shifted;
  logic [PW-DATA_WIDTH:0]       top_bits;
  logic signed [DATA_WIDTH-1:0] prod_sat;
  logic signed [DATA_WIDTH-1:0] lhs;
  logic signed [DATA_WIDTH:0]   sum;

  assign prod    = a * b;
  assign shifted = ctl.rate_shift ? (prod >>> RATE_FRAC) : (prod >>> FRAC_BITS);
  assign top_bits = shifted[PW-1:DATA_WIDTH-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      prod_sat = shifted[DATA_WIDTH-1:0];
    end else if (shifted[PW-1]) begin
      prod_sat = VMIN;
    end else begin
      prod_sat = VMAX;
    end
  end

  assign lhs = (ctl.op == ALU_MULADD) ? prod_sat : a;

  always_comb begin
    if (ctl.op == ALU_SUB) begin
      sum = {lhs[DATA_WIDTH-1], lhs} - {c[DATA_WIDTH-1], c};
    end else begin
      sum = {lhs[DATA_WIDTH-1], lhs} + {c[DATA_WIDTH-1], c};
    end
  end

  always_comb begin
    if (sum[DATA_WIDTH] == sum[DATA_WIDTH-1]) begin
      res = sum[DATA_WIDTH-1:0];
    end else if (sum[DATA_WIDTH]) begin
      res = VMIN;
    end else begin
      res = VMAX;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lrsgd_cfg.sv =====
// ----------------------------------------------------------------------------
// lrsgd_cfg
// APB register slave holding the learning rate.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsgd_cfg
  import lrsgd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready,
  output logic [LR_W-1:0]            step_rate
);

  logic [LR_W-1:0] lr_r;
  logic            sel_lr;

  assign sel_lr = (paddr[CFG_ADDR_W-1] == REG_IDX_LR);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RESET;
    end else if (psel && penable && pwrite && sel_lr) begin
      lr_r <= pwdata[LR_W-1:0];
    end
  end

  assign prdata    = sel_lr ? {{(CFG_DATA_W-LR_W){1'b0}}, lr_r} : '0;
  assign step_rate = lr_r;

endmodule

`default_nettype wire

// ===== sv/linear_regression_sgd_update.sv =====
// ----------------------------------------------------------------------------
// linear_regression_sgd_update
// Online single-variable linear regression trainer, one SGD step per pair with nonzero x.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_stall, in_x_value, in_y_reference | to block
//   out     | out_valid, out_stall, out_new_weight,          | from block
//           | out_new_bias, out_pred_error                   |
//   cfg     | cfg_p*, step rate at paddr 0-3                 | to block
//
// A pair with nonzero x takes five steps of the shared multiply/add unit,
// then the hand-off state, which waits while the output is held, and the
// idle state. A pair with zero x sets the bias to y and goes to hand-off.
// Reset clears weight and bias and loads the default learning rate.
// A stalled result holds in the output register; the next transaction
// is accepted meanwhile and waits before hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_regression_sgd_update
  import lrsgd_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [DATA_WIDTH-1:0] in_x_value,
  input  wire logic signed [DATA_WIDTH-1:0] in_y_reference,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_new_weight,
  output logic signed [DATA_WIDTH-1:0]      out_new_bias,
  output logic signed [DATA_WIDTH-1:0]      out_pred_error,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]        cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [CFG_DATA_W-1:0]             cfg_prdata,
  output logic                              cfg_pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_ERR  = 3'd2;
  localparam logic [2:0] ST_DB   = 3'd3;
  localparam logic [2:0] ST_WGT  = 3'd4;
  localparam logic [2:0] ST_BIAS = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]                   state_r;
  logic signed [DATA_WIDTH-1:0] x_r;
  logic signed [DATA_WIDTH-1:0] y_r;
  logic signed [DATA_WIDTH-1:0] weight_r;
  logic signed [DATA_WIDTH-1:0] bias_r;
  logic signed [DATA_WIDTH-1:0] pred_r;
  logic signed [DATA_WIDTH-1:0] err_r;
  logic signed [DATA_WIDTH-1:0] db_r;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_weight_r;
  logic signed [DATA_WIDTH-1:0] out_bias_r;
  logic signed [DATA_WIDTH-1:0] out_err_r;

  logic [LR_W-1:0]              step_rate;
  alu_ctl_t                     alu_ctl;
  logic signed [DATA_WIDTH-1:0] alu_a;
  logic signed [DATA_WIDTH:0]   alu_b;
  logic signed [DATA_WIDTH-1:0] alu_c;
  logic signed [DATA_WIDTH-1:0] alu_res;
  logic signed [DATA_WIDTH:0]   x_ext;
  logic signed [DATA_WIDTH:0]   lr_ext;
  logic                         in_fire;
  logic                         out_free;

  lrsgd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .step_rate (step_rate)
  );

  lrsgd_alu #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_alu (
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .res (alu_res)
  );

  assign x_ext  = {x_r[DATA_WIDTH-1], x_r};
  assign lr_ext = {{(DATA_WIDTH+1-LR_W){1'b0}}, step_rate};

  always_comb begin
    alu_ctl = '{op: ALU_ADD, rate_shift: 1'b0};
    alu_a   = '0;
    alu_b   = '0;
    alu_c   = '0;
    unique case (state_r)
      ST_PRED: begin
        alu_ctl = '{op: ALU_MULADD, rate_shift: 1'b0};
        alu_a   = weight_r;
        alu_b   = x_ext;
        alu_c   = bias_r;
      end
      ST_ERR: begin
        alu_ctl = '{op: ALU_SUB, rate_shift: 1'b0};
        alu_a   = y_r;
        alu_c   = pred_r;
      end
      ST_DB: begin
        alu_ctl = '{op: ALU_MULADD, rate_shift: 1'b1};
        alu_a   = err_r;
        alu_b   = lr_ext;
      end
      ST_WGT: begin
        alu_ctl = '{op: ALU_MULADD, rate_shift: 1'b0};
        alu_a   = db_r;
        alu_b   = x_ext;
        alu_c   = weight_r;
      end
      ST_BIAS: begin
        alu_a   = bias_r;
        alu_c   = db_r;
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE) || !rst_n;
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      weight_r <= '0;
      bias_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_x_value == '0) begin
              bias_r  <= in_y_reference;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_PRED;
            end
          end
        end
        ST_PRED: state_r <= ST_ERR;
        ST_ERR:  state_r <= ST_DB;
        ST_DB:   state_r <= ST_WGT;
        ST_WGT: begin
          weight_r <= alu_res;
          state_r  <= ST_BIAS;
        end
        ST_BIAS: begin
          bias_r  <= alu_res;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r   <= in_x_value;
      y_r   <= in_y_reference;
      err_r <= '0;
    end
    if (state_r == ST_PRED) begin
      pred_r <= alu_res;
    end
    if (state_r == ST_ERR) begin
      err_r <= alu_res;
    end
    if (state_r == ST_DB) begin
      db_r <= alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_weight_r <= weight_r;
      out_bias_r   <= bias_r;
      out_err_r    <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_weight = out_weight_r;
  assign out_new_bias   = out_bias_r;
  assign out_pred_error = out_err_r;

endmodule

`default_nettype wire
